// ===== hw/rtl/lcas_pkg.sv =====
package lcas_pkg;

   // grid bounds
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;

   // field and register widths
   localparam int KIND_W = 2;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CFG_W  = 7;
   localparam int IDX_W  = 2;

   // sweep: prime the window, then one row written per cycle
   localparam int SWEEP_LAST = MAX_ROWS + 1;
   localparam int CNT_W      = $clog2(SWEEP_LAST + 1);
   localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam int RESET_SIZE = 64;

   typedef logic [CFG_W-1:0]    cfg_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CMP_W-1:0]    cmp_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [COL_W-1:0]    col_type;
   typedef logic [ROW_W:0]      addr_type;
   typedef logic [MAX_COLS-1:0] line_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_COLS = 2'd0,
      CSR_ROWS = 2'd1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   // one column of the three-row window
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } lcas_col_type;

   // shared control for the cell row
   typedef struct packed {
      logic clear;
      logic shift;
   } lcas_ctl_type;

   function automatic cfg_type clamp_size(input cfg_type v, input int top);
      cfg_type r;
      if (v == '0) begin
         r = cfg_type'(1);
      end else if (int'(v) > top) begin
         r = cfg_type'(top);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/lcas_cell.sv =====
module lcas_cell (
   input  logic                  clock,
   input  lcas_pkg::lcas_ctl_type ctl,
   input  logic                  col_en,
   input  logic                  row_bit,
   input  lcas_pkg::lcas_col_type left,
   input  lcas_pkg::lcas_col_type right,
   output lcas_pkg::lcas_col_type self_col,
   output logic                  next_bit
);

   logic       top_ff, top_in;
   logic       mid_ff, mid_in;
   logic       bot;
   logic [3:0] sum;

   // columns beyond the grid in use read as dead
   assign bot = row_bit & col_en;

   always_comb begin
      top_in = top_ff;
      mid_in = mid_ff;
      if (ctl.clear) begin
         top_in = 1'b0;
         mid_in = 1'b0;
      end else if (ctl.shift) begin
         top_in = mid_ff;
         mid_in = bot;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      mid_ff <= mid_in;
   end

   assign sum = 4'(left.top) + 4'(left.mid) + 4'(left.bot)
              + 4'(top_ff) + 4'(bot)
              + 4'(right.top) + 4'(right.mid) + 4'(right.bot);

   // B3/S23
   assign next_bit = col_en & ((sum == 4'd3) | (mid_ff & (sum == 4'd2)));

   assign self_col = '{top: top_ff, mid: mid_ff, bot: bot};

endmodule

// ===== hw/rtl/life_cellular_automaton_step_core.sv =====
// Channel  | Ports                                          | Accepted when
// ---------+------------------------------------------------+---------------------------
// request  | req_kind, req_cell_col, req_cell_row,          | req_valid & req_ready
//          | req_cell_value                                 |
// response | rsp_read_value, rsp_step_done                  | rsp_valid & rsp_ready
// csr      | csr_index, csr_wdata                           | csr_we
//
// Timing: a cell write, or an unused kind, answers at the accepting edge; a cell read
// passes through one registered read of the grid memory; an advance runs a
// one-row-per-cycle sweep of the grid memory through the row of column cells,
// after a window prime.
// Reset: synchronous, active high; both banks read as dead via per-row valid bits.
// Stalls: a new item is taken only when idle and the response register is free
// or being emptied in the same cycle.
module life_cellular_automaton_step_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lcas_pkg::KIND_W-1:0]   req_kind,
   input  logic [lcas_pkg::COL_W-1:0]    req_cell_col,
   input  logic [lcas_pkg::ROW_W-1:0]    req_cell_row,
   input  logic                          req_cell_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_read_value,
   output logic                          rsp_step_done,
   input  logic                          csr_we,
   input  logic [lcas_pkg::IDX_W-1:0]    csr_index,
   input  logic [lcas_pkg::CFG_W-1:0]    csr_wdata
);

   // control state
   lcas_pkg::state_type state_ff, state_in;
   lcas_pkg::cnt_type   cnt_ff, cnt_in;
   logic                active_ff, active_in;
   lcas_pkg::cfg_type   cols_ff, cols_in;
   lcas_pkg::cfg_type   rows_ff, rows_in;
   logic [1:0][lcas_pkg::MAX_ROWS-1:0] valid_ff, valid_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_read_ff, rsp_read_in;
   logic rsp_step_ff, rsp_step_in;

   // read-side registers
   lcas_pkg::col_type  col_sel_ff, col_sel_in;
   logic               rd_zero_ff, rd_zero_in;
   lcas_pkg::line_type mem_rd_ff;

   // grid memory: bank in the top address bit, one row of cells per entry
   lcas_pkg::line_type grid_mem [2*lcas_pkg::MAX_ROWS];

   lcas_pkg::addr_type rd_addr;
   lcas_pkg::addr_type wr_addr;
   logic               wr_en;
   lcas_pkg::line_type wr_data;
   lcas_pkg::line_type wr_mask;

   // cell row
   lcas_pkg::lcas_ctl_type cell_ctl;
   lcas_pkg::lcas_col_type col_win [lcas_pkg::MAX_COLS+2];
   lcas_pkg::line_type     next_row;
   lcas_pkg::line_type     row_bits;
   lcas_pkg::line_type     col_en;

   logic               accept;
   logic               in_grid;
   logic               cnt_last;
   logic               rd_row_live;
   logic               wr_row_live;
   lcas_pkg::cnt_type  wr_row;
   lcas_pkg::row_type  cnt_row;

   assign req_ready = (state_ff == lcas_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign in_grid = (lcas_pkg::cfg_type'(req_cell_col) < cols_ff)
                 && (lcas_pkg::cfg_type'(req_cell_row) < rows_ff);

   assign cnt_last = cnt_ff == lcas_pkg::cnt_type'(lcas_pkg::SWEEP_LAST);
   assign cnt_row  = cnt_ff[lcas_pkg::ROW_W-1:0];
   // the read one past the last row feeds the window with a dead row
   assign rd_row_live = (int'(cnt_ff) < lcas_pkg::MAX_ROWS)
                     && (lcas_pkg::cmp_type'(cnt_ff) < lcas_pkg::cmp_type'(rows_ff));
   // row written this cycle trails the row being read by two
   assign wr_row      = cnt_ff - lcas_pkg::cnt_type'(2);
   assign wr_row_live = lcas_pkg::cmp_type'(wr_row) < lcas_pkg::cmp_type'(rows_ff);

   // rows out of use, or never written since reset, enter as dead
   assign row_bits = mem_rd_ff & {lcas_pkg::MAX_COLS{!rd_zero_ff}};

   assign col_win[0]                      = '0;
   assign col_win[lcas_pkg::MAX_COLS + 1] = '0;

   for (genvar c = 0; c < lcas_pkg::MAX_COLS; c++) begin : g_cell
      assign col_en[c] = lcas_pkg::cmp_type'(c) < lcas_pkg::cmp_type'(cols_ff);

      lcas_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .col_en   (col_en[c]),
         .row_bit  (row_bits[c]),
         .left     (col_win[c]),
         .right    (col_win[c+2]),
         .self_col (col_win[c+1]),
         .next_bit (next_row[c])
      );
   end

   // main control
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      active_in   = active_ff;
      valid_in    = valid_ff;
      col_sel_in  = col_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_step_in  = rsp_step_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rd_addr    = {active_ff, req_cell_row};
      rd_zero_in = !in_grid || !valid_ff[active_ff][req_cell_row];
      wr_en      = 1'b0;
      wr_addr    = {active_ff, req_cell_row};
      wr_data    = '0;
      wr_mask    = '0;
      cell_ctl   = '0;

      case (state_ff)
         lcas_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  lcas_pkg::KIND_WRITE: begin
                     if (in_grid) begin
                        wr_en   = 1'b1;
                        wr_data = lcas_pkg::line_type'(req_cell_value) << req_cell_col;
                        // first write to a row since reset clears the rest of it
                        wr_mask = valid_ff[active_ff][req_cell_row]
                                ? (lcas_pkg::line_type'(1) << req_cell_col) : '1;
                        valid_in[active_ff][req_cell_row] = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_read_in  = 1'b0;
                     rsp_step_in  = 1'b0;
                  end
                  lcas_pkg::KIND_STEP: begin
                     state_in = lcas_pkg::ST_SWEEP;
                     cnt_in   = '0;
                  end
                  lcas_pkg::KIND_READ: begin
                     state_in   = lcas_pkg::ST_READ;
                     col_sel_in = req_cell_col;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_read_in  = 1'b0;
                     rsp_step_in  = 1'b0;
                  end
               endcase
            end
         end
         lcas_pkg::ST_SWEEP: begin
            rd_addr        = {active_ff, cnt_row};
            rd_zero_in     = !rd_row_live || !valid_ff[active_ff][cnt_row];
            cell_ctl.clear = cnt_ff == '0;
            cell_ctl.shift = cnt_ff != '0;
            if (cnt_ff >= lcas_pkg::cnt_type'(2)) begin
               wr_en   = 1'b1;
               wr_addr = {!active_ff, wr_row[lcas_pkg::ROW_W-1:0]};
               wr_data = next_row & {lcas_pkg::MAX_COLS{wr_row_live}};
               wr_mask = '1;
               valid_in[!active_ff][wr_row[lcas_pkg::ROW_W-1:0]] = 1'b1;
            end
            if (cnt_last) begin
               state_in     = lcas_pkg::ST_IDLE;
               active_in    = !active_ff;
               rsp_valid_in = 1'b1;
               rsp_read_in  = 1'b0;
               rsp_step_in  = 1'b1;
            end else begin
               cnt_in = cnt_ff + lcas_pkg::cnt_type'(1);
            end
         end
         lcas_pkg::ST_READ: begin
            state_in     = lcas_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_read_in  = mem_rd_ff[col_sel_ff] & !rd_zero_ff;
            rsp_step_in  = 1'b0;
         end
         default: begin
            state_in = lcas_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration, clamped on the way in
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         case (csr_index)
            lcas_pkg::CSR_COLS: cols_in = lcas_pkg::clamp_size(csr_wdata, lcas_pkg::MAX_COLS);
            lcas_pkg::CSR_ROWS: rows_in = lcas_pkg::clamp_size(csr_wdata, lcas_pkg::MAX_ROWS);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcas_pkg::ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= lcas_pkg::clamp_size(lcas_pkg::cfg_type'(lcas_pkg::RESET_SIZE),
                                              lcas_pkg::MAX_COLS);
         rows_ff      <= lcas_pkg::clamp_size(lcas_pkg::cfg_type'(lcas_pkg::RESET_SIZE),
                                              lcas_pkg::MAX_ROWS);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_read_ff <= rsp_read_in;
      rsp_step_ff <= rsp_step_in;
      col_sel_ff  <= col_sel_in;
      rd_zero_ff  <= rd_zero_in;
   end

   // grid memory: one masked write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < lcas_pkg::MAX_COLS; b++) begin
            if (wr_mask[b]) begin
               grid_mem[wr_addr][b] <= wr_data[b];
            end
         end
      end
      mem_rd_ff <= grid_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_step_done  = rsp_step_ff;

`ifndef SYNTHESIS
   // the last sweep cycle delivers the advance item and frees the block
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcas_pkg::ST_SWEEP) && cnt_last |=>
         (state_ff == lcas_pkg::ST_IDLE) && rsp_valid_ff && rsp_step_ff && !rsp_read_ff)
      else $error("advance did not complete after the sweep");

   // banks swap only at the end of a sweep
   a_swap: assert property (@(posedge clock) disable iff (reset)
      (active_ff != $past(active_ff)) |->
         ($past(state_ff) == lcas_pkg::ST_SWEEP) && $past(cnt_last))
      else $error("bank swap outside sweep end");

   // no item is taken mid-sweep or mid-read
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lcas_pkg::ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");

   // a pending response is never overwritten by a new one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_step_ff)
         && $stable(rsp_read_ff))
      else $error("response overwritten before taken");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lcas_pkg::*;

   // kind 3 is left unused by the block; it must answer with both fields low
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
   // register indexes beyond the list, writes to them are dropped
   localparam logic [IDX_W-1:0]  CSR_SPARE_LO = 2'd2;
   localparam logic [IDX_W-1:0]  CSR_SPARE_HI = 2'd3;

   localparam int MAX_GAP       = 14;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 135;
   localparam int REPORT_CAP    = 100;

   // one expected answer, with the item that caused it kept for messages
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              read_value;
      logic              step_done;
   } life_answer_type;

   // every input is known from time zero
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [KIND_W-1:0] req_kind       = '0;
   logic [COL_W-1:0]  req_cell_col   = '0;
   logic [ROW_W-1:0]  req_cell_row   = '0;
   logic              req_cell_value = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic              rsp_read_value;
   logic              rsp_step_done;
   logic              csr_we         = 1'b0;
   logic [IDX_W-1:0]  csr_index      = '0;
   logic [CFG_W-1:0]  csr_wdata      = '0;

   // shadow of the block: two banks, current bank select and clamped sizes
   logic [MAX_COLS-1:0] life_bank [2][MAX_ROWS];
   logic                live_bank;
   int                  grid_cols;
   int                  grid_rows;

   life_answer_type answers_due [$];
   int              mismatch_count = 0;

   // idling switches, flipped per phase so some stretches run flat out
   logic send_gaps_on  = 1'b1;
   logic stall_gaps_on = 1'b1;

   always #10 clock = ~clock;

   life_cellular_automaton_step_core dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_kind,
      .req_cell_col,
      .req_cell_row,
      .req_cell_value,
      .rsp_valid,
      .rsp_ready,
      .rsp_read_value,
      .rsp_step_done,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   // ------------------------------------------------------------------
   // Shadow grid
   // ------------------------------------------------------------------

   // 0 behaves as 1, anything above the bound saturates
   function automatic int fit_size(input logic [CFG_W-1:0] v, input int top);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > top) begin
         return top;
      end
      return int'(v);
   endfunction

   // cells off the grid in use count dead: no wraparound
   function automatic int cell_alive(input int r, input int c);
      if (r < 0 || c < 0 || r >= grid_rows || c >= grid_cols) begin
         return 0;
      end
      return int'(life_bank[live_bank][r][c]);
   endfunction

   // B3/S23 into the idle bank, cells outside the grid written dead, then swap
   function automatic void next_generation();
      logic [MAX_COLS-1:0] fresh [MAX_ROWS];
      int                  nb;
      for (int r = 0; r < MAX_ROWS; r++) begin
         fresh[r] = '0;
         for (int c = 0; c < MAX_COLS; c++) begin
            if (r < grid_rows && c < grid_cols) begin
               nb = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     if (dr != 0 || dc != 0) begin
                        nb += cell_alive(r + dr, c + dc);
                     end
                  end
               end
               fresh[r][c] = (nb == 3) || (nb == 2 && life_bank[live_bank][r][c]);
            end
         end
      end
      for (int r = 0; r < MAX_ROWS; r++) begin
         life_bank[!live_bank][r] = fresh[r];
      end
      live_bank = !live_bank;
   endfunction

   function automatic life_answer_type life_predict(input logic [KIND_W-1:0] kind,
                                                    input logic [COL_W-1:0]  col,
                                                    input logic [ROW_W-1:0]  row,
                                                    input logic              val);
      life_answer_type ans;
      logic            in_grid;
      ans      = '0;
      ans.kind = kind;
      ans.col  = col;
      ans.row  = row;
      in_grid  = (int'(col) < grid_cols) && (int'(row) < grid_rows);
      case (kind)
         KIND_WRITE: begin
            if (in_grid) begin
               life_bank[live_bank][row][col] = val;
            end
         end
         KIND_STEP: begin
            next_generation();
            ans.step_done = 1'b1;
         end
         KIND_READ: begin
            if (in_grid) begin
               ans.read_value = life_bank[live_bank][row][col];
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------
   // Shared driving and checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) begin
         $display("[%0t] MISMATCH %s", $time, what);
      end
   endtask

   // valid is only dropped when a gap is drawn, so back-to-back items keep it high
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [COL_W-1:0]  col,
                            input logic [ROW_W-1:0]  row,
                            input logic              val);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_cell_col   <= col;
      req_cell_row   <= row;
      req_cell_value <= val;
      do @(posedge clock); while (!req_ready);
      answers_due.push_back(life_predict(kind, col, row, val));
   endtask

   // hold the sender until every answer is back, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (answers_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // registers only move while the block is idle
   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_COLS: begin
            grid_cols = fit_size(value, MAX_COLS);
         end
         CSR_ROWS: begin
            grid_rows = fit_size(value, MAX_ROWS);
         end
         default: begin
         end
      endcase
   endtask

   // response side: random stall per item, compare against the oldest answer due
   initial begin : answer_checker
      life_answer_type due;
      int              stall;
      wait (reset == 1'b0);
      forever begin
         stall = stall_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (answers_due.size() == 0) begin
            report_mismatch("response with no item outstanding");
         end else begin
            due = answers_due.pop_front();
            if (rsp_read_value !== due.read_value) begin
               report_mismatch($sformatf("read_value %b, want %b (kind %0d col %0d row %0d)",
                  rsp_read_value, due.read_value, due.kind, due.col, due.row));
            end
            if (rsp_step_done !== due.step_done) begin
               report_mismatch($sformatf("step_done %b, want %b (kind %0d col %0d row %0d)",
                  rsp_step_done, due.step_done, due.kind, due.col, due.row));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // fresh out of reset: all dead, unused kind, advance of an empty grid
   task automatic test_empty_grid();
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd63, 6'd63, 1'b1);
      send_item(KIND_UNUSED, 6'd63, 6'd63, 1'b1);
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd32, 6'd31, 1'b0);
   endtask

   // corner cells, and blinkers hugging the edges to catch any wraparound
   task automatic test_edges_no_wrap();
      send_item(KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_item(KIND_WRITE, 6'd63, 6'd63, 1'b1);
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd63, 6'd63, 1'b0);
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd63, 6'd63, 1'b0);
      // horizontal blinker on the top row
      for (int c = 0; c < 3; c++) begin
         send_item(KIND_WRITE, COL_W'(c), 6'd0, 1'b1);
      end
      // vertical blinker on the left column
      for (int r = 30; r < 33; r++) begin
         send_item(KIND_WRITE, 6'd0, ROW_W'(r), 1'b1);
      end
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd1, 6'd1, 1'b0);
      send_item(KIND_READ, 6'd1, 6'd63, 1'b0);
      send_item(KIND_READ, 6'd63, 6'd31, 1'b0);
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
      send_item(KIND_WRITE, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
   endtask

   // clamping, spare indexes, off-grid writes and reads, clearing on advance
   task automatic test_register_limits();
      write_csr(CSR_COLS, 7'd0);
      write_csr(CSR_ROWS, 7'd0);
      send_item(KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_item(KIND_WRITE, 6'd1, 6'd0, 1'b1);
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd1, 6'd0, 1'b0);
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(KIND_READ, 6'd0, 6'd0, 1'b0);
      write_csr(CSR_COLS, 7'd127);
      write_csr(CSR_ROWS, 7'd127);
      write_csr(CSR_SPARE_LO, 7'd5);
      write_csr(CSR_SPARE_HI, 7'd3);
      send_item(KIND_WRITE, 6'd40, 6'd40, 1'b1);
      write_csr(CSR_COLS, 7'd5);
      write_csr(CSR_ROWS, 7'd4);
      send_item(KIND_READ, 6'd40, 6'd40, 1'b0);
      send_item(KIND_WRITE, 6'd4, 6'd3, 1'b1);
      send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
      write_csr(CSR_COLS, 7'd64);
      write_csr(CSR_ROWS, 7'd64);
      send_item(KIND_READ, 6'd40, 6'd40, 1'b0);
      send_item(KIND_READ, 6'd4, 6'd3, 1'b0);
   endtask

   // per phase: pick a grid, seed a dense patch, then mixed writes, reads and advances
   task automatic test_random_generations();
      logic [CFG_W-1:0] cw;
      logic [CFG_W-1:0] rw;
      int               win_cols;
      int               win_rows;
      int               org_col;
      int               org_row;
      int               seeds;
      int               pick;
      int               c;
      int               r;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               cw = 7'd64;
               rw = 7'd64;
            end
            1: begin
               cw = 7'd8;
               rw = 7'd8;
            end
            2: begin
               cw = 7'd3;
               rw = 7'd3;
            end
            3: begin
               cw = 7'd1;
               rw = 7'd64;
            end
            4: begin
               cw = 7'd64;
               rw = 7'd1;
            end
            5: begin
               cw = 7'd0;
               rw = 7'd0;
            end
            6: begin
               cw = 7'd127;
               rw = 7'd127;
            end
            7: begin
               cw = 7'd5;
               rw = 7'd12;
            end
            default: begin
               cw = CFG_W'($urandom_range(1, MAX_COLS));
               rw = CFG_W'($urandom_range(1, MAX_ROWS));
            end
         endcase
         write_csr(CSR_COLS, cw);
         write_csr(CSR_ROWS, rw);
         // first phase runs with no idling on either side
         send_gaps_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
         stall_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         win_cols = (grid_cols < 10) ? grid_cols : 10;
         win_rows = (grid_rows < 10) ? grid_rows : 10;
         org_col  = $urandom_range(0, grid_cols - win_cols);
         org_row  = $urandom_range(0, grid_rows - win_rows);
         seeds    = win_cols * win_rows / 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one sender hold-off mid-phase, on odd phases
            if (n == PHASE_ITEMS / 2 && phase[0]) begin
               settle();
            end
            pick = (n < seeds) ? 0 : $urandom_range(0, 99);
            // most cells land in the seeded patch, some anywhere on the grid
            if ($urandom_range(0, 9) < 7) begin
               c = org_col + $urandom_range(0, win_cols - 1);
               r = org_row + $urandom_range(0, win_rows - 1);
            end else begin
               c = $urandom_range(0, grid_cols - 1);
               r = $urandom_range(0, grid_rows - 1);
            end
            if (pick < 40) begin
               send_item(KIND_WRITE, COL_W'(c), ROW_W'(r), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
               send_item(KIND_READ, COL_W'(c), ROW_W'(r), 1'($urandom_range(0, 1)));
            end else if (pick < 87) begin
               send_item(KIND_STEP, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
            end else if (pick < 90) begin
               send_item(KIND_UNUSED, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
            end else begin
               // off-grid or anywhere: full field range
               send_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ,
                         COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
            end
         end
      end
      send_gaps_on  = 1'b1;
      stall_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      for (int r = 0; r < MAX_ROWS; r++) begin
         life_bank[0][r] = '0;
         life_bank[1][r] = '0;
      end
      live_bank = 1'b0;
      grid_cols = RESET_SIZE;
      grid_rows = RESET_SIZE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_grid();
      test_edges_no_wrap();
      test_register_limits();
      test_random_generations();
      settle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, well clear of the slowest legal run
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
